>>> rtl/rwcp_pkg.sv
// Shared types, widths and pipeline latencies for the wall column projection.
// No dependencies; imported by every module in rtl/.
package rwcp_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int COORD_W     = 24;
    localparam int HEAD_W      = 16;
    localparam int SQ_W        = 49;              // dx^2 + dy^2
    localparam int RAW_W       = 25;              // floor sqrt of SQ_W bits
    localparam int SQ_PAD_W    = 2 * RAW_W;
    localparam int REM_W       = RAW_W + 2;
    localparam int CORR_W      = 25;
    localparam int H_W         = 24;
    localparam int MAG_W       = 17;              // Q1.16 cosine magnitude
    localparam int NUM_W       = 40;              // tile_height * proj_plane_distance

    localparam int DIST_LAT    = 4;
    localparam int SQRT_STAGES = RAW_W;
    localparam int COS_LAT     = 7;
    localparam int COS_DLY     = DIST_LAT + SQRT_STAGES - COS_LAT;
    localparam int DIV_STAGES  = H_W;
    localparam int TOTAL_LAT   = DIST_LAT + SQRT_STAGES + 1 + DIV_STAGES + 1;

    localparam logic [1:0] IDX_PROJ   = 2'd0;
    localparam logic [1:0] IDX_TILE   = 2'd1;
    localparam logic [1:0] IDX_SCREEN = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] hy;
    } ray_in_t;

    typedef struct packed {
        logic               horiz;
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
    } side_t;

    typedef struct packed {
        logic             pos;
        logic [MAG_W-1:0] mag;
    } cos_t;

    typedef struct packed {
        side_t             s;
        logic [RAW_W-1:0]  raw;
        logic [CORR_W-1:0] corr;
    } out_side_t;

endpackage

>>> rtl/rwcp_dist.sv
// Squared distance to both wall hits and nearer-hit select, four stages.
// Depends on rwcp_pkg.
module rwcp_dist
    import rwcp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ray_in_t         in_ray,
    output logic            out_valid,
    output logic [SQ_W-1:0] out_sq,
    output side_t           out_side
);

    logic [COORD_W-1:0] dvx_next, dvy_next, dhx_next, dhy_next;
    logic [COORD_W-1:0] dvx_reg, dvy_reg, dhx_reg, dhy_reg;
    logic [2*COORD_W-1:0] svx_reg, svy_reg, shx_reg, shy_reg;
    logic [SQ_W-1:0] vd2_reg, hd2_reg, sq_reg;
    logic [COORD_W-1:0] vx_reg [3];
    logic [COORD_W-1:0] vy_reg [3];
    logic [COORD_W-1:0] hx_reg [3];
    logic [COORD_W-1:0] hy_reg [3];
    logic [3:0] valid_reg;
    side_t side_reg;

    always_comb
    begin
        dvx_next = (in_ray.px > in_ray.vx) ? in_ray.px - in_ray.vx : in_ray.vx - in_ray.px;
        dvy_next = (in_ray.py > in_ray.vy) ? in_ray.py - in_ray.vy : in_ray.vy - in_ray.py;
        dhx_next = (in_ray.px > in_ray.hx) ? in_ray.px - in_ray.hx : in_ray.hx - in_ray.px;
        dhy_next = (in_ray.py > in_ray.hy) ? in_ray.py - in_ray.hy : in_ray.hy - in_ray.py;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        // stage 1: absolute differences
        dvx_reg   <= dvx_next;
        dvy_reg   <= dvy_next;
        dhx_reg   <= dhx_next;
        dhy_reg   <= dhy_next;
        vx_reg[0] <= in_ray.vx;
        vy_reg[0] <= in_ray.vy;
        hx_reg[0] <= in_ray.hx;
        hy_reg[0] <= in_ray.hy;
        // stage 2: squares
        svx_reg   <= dvx_reg * dvx_reg;
        svy_reg   <= dvy_reg * dvy_reg;
        shx_reg   <= dhx_reg * dhx_reg;
        shy_reg   <= dhy_reg * dhy_reg;
        vx_reg[1] <= vx_reg[0];
        vy_reg[1] <= vy_reg[0];
        hx_reg[1] <= hx_reg[0];
        hy_reg[1] <= hy_reg[0];
        // stage 3: sums
        vd2_reg   <= {1'b0, svx_reg} + {1'b0, svy_reg};
        hd2_reg   <= {1'b0, shx_reg} + {1'b0, shy_reg};
        vx_reg[2] <= vx_reg[1];
        vy_reg[2] <= vy_reg[1];
        hx_reg[2] <= hx_reg[1];
        hy_reg[2] <= hy_reg[1];
        // stage 4: nearer hit, tie to horizontal
        if (hd2_reg <= vd2_reg)
        begin
            sq_reg         <= hd2_reg;
            side_reg.horiz <= 1'b1;
            side_reg.wx    <= hx_reg[2];
            side_reg.wy    <= hy_reg[2];
        end
        else
        begin
            sq_reg         <= vd2_reg;
            side_reg.horiz <= 1'b0;
            side_reg.wx    <= vx_reg[2];
            side_reg.wy    <= vy_reg[2];
        end
    end

    assign out_valid = valid_reg[3];
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/rwcp_cos.sv
// Cosine of the heading difference, quarter-wave fold plus Horner polynomial.
// Depends on rwcp_pkg; the output is registered.
module rwcp_cos
    import rwcp_pkg::*;
(
    input  logic              clk,
    input  logic [HEAD_W-1:0] ray_heading,
    input  logic [HEAD_W-1:0] view_heading,
    output cos_t              out_cos
);

    localparam logic [5:0]  P0 = 6'd60;
    localparam logic [10:0] P1 = 11'd1367;
    localparam logic [14:0] P2 = 15'd16624;
    localparam logic [16:0] P3 = 17'd80852;
    localparam logic [17:0] ONE = 18'd65536;

    logic [HEAD_W-1:0]     diff;
    logic [ANGLE_BITS-1:0] ang;
    logic [31:0]           a_full;
    logic [30:0]           r_inv;
    logic [16:0]           t_next;
    logic [10:0]           p1;
    logic [14:0]           p2;
    logic [16:0]           p3;
    logic [17:0]           x4;
    cos_t                  cos_next;

    logic [16:0] t_reg;
    logic [33:0] tt_reg;
    logic [16:0] u2_reg [3:5];
    logic [1:0]  q_reg  [1:6];
    logic [22:0] m1_reg;
    logic [27:0] m2_reg;
    logic [31:0] m3_reg;
    logic [33:0] m4_reg;
    cos_t        cos_reg;

    always_comb
    begin
        diff   = ray_heading - view_heading;
        ang    = diff[ANGLE_BITS-1:0];
        a_full = {ang, {(32-ANGLE_BITS){1'b0}}};
        r_inv  = 31'h4000_0000 - {1'b0, a_full[29:0]};
        t_next = a_full[30] ? r_inv[30:14] : {1'b0, a_full[29:14]};
        p1     = P1 - {4'b0, m1_reg[22:16]};
        p2     = P2 - {3'b0, m2_reg[27:16]};
        p3     = P3 - {1'b0, m3_reg[31:16]};
        x4     = m4_reg[33:16];
        cos_next.mag = (x4 > ONE) ? '0 : MAG_W'(ONE - x4);
        cos_next.pos = ((q_reg[6] == 2'd0) || (q_reg[6] == 2'd3)) && (cos_next.mag != '0);
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        q_reg[1]  <= a_full[31:30];
        tt_reg    <= t_reg * t_reg;
        q_reg[2]  <= q_reg[1];
        u2_reg[3] <= tt_reg[32:16];
        m1_reg    <= P0 * tt_reg[32:16];
        q_reg[3]  <= q_reg[2];
        m2_reg    <= p1 * u2_reg[3];
        u2_reg[4] <= u2_reg[3];
        q_reg[4]  <= q_reg[3];
        m3_reg    <= p2 * u2_reg[4];
        u2_reg[5] <= u2_reg[4];
        q_reg[5]  <= q_reg[4];
        m4_reg    <= p3 * u2_reg[5];
        q_reg[6]  <= q_reg[5];
        cos_reg   <= cos_next;
    end

    assign out_cos = cos_reg;

endmodule

>>> rtl/rwcp_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on rwcp_pkg.
module rwcp_sqrt
    import rwcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [SQ_W-1:0]  in_sq,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [RAW_W-1:0] out_root,
    output side_t            out_side
);

    logic                valid_reg [SQRT_STAGES];
    logic [SQ_PAD_W-1:0] rad_reg   [SQRT_STAGES];
    logic [REM_W-1:0]    rem_reg   [SQRT_STAGES];
    logic [RAW_W-1:0]    root_reg  [SQRT_STAGES];
    side_t               side_reg  [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stage
            logic                v_src;
            logic [SQ_PAD_W-1:0] rad_src;
            logic [REM_W-1:0]    rem_src;
            logic [RAW_W-1:0]    root_src;
            side_t               side_src;
            logic [REM_W-1:0]    rem_sh;
            logic [REM_W-1:0]    trial;

            if (k == 0)
            begin : g_first
                assign v_src    = in_valid;
                assign rad_src  = {{(SQ_PAD_W-SQ_W){1'b0}}, in_sq};
                assign rem_src  = '0;
                assign root_src = '0;
                assign side_src = in_side;
            end
            else
            begin : g_next
                assign v_src    = valid_reg[k-1];
                assign rad_src  = rad_reg[k-1];
                assign rem_src  = rem_reg[k-1];
                assign root_src = root_reg[k-1];
                assign side_src = side_reg[k-1];
            end

            assign rem_sh = {rem_src[REM_W-3:0], rad_src[SQ_PAD_W-1 -: 2]};
            assign trial  = {root_src, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                rad_reg[k]  <= {rad_src[SQ_PAD_W-3:0], 2'b00};
                side_reg[k] <= side_src;
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_src[RAW_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_src[RAW_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

>>> rtl/rwcp_div.sv
// Pipelined restoring divider with 24-bit saturating quotient, one bit per stage.
// Depends on rwcp_pkg.
module rwcp_div
    import rwcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [H_W-1:0]    num_hi,     // dividend bits 47:24
    input  logic [15:0]       num_lo,     // dividend bits 23:8, bits 7:0 are zero
    input  logic [CORR_W-1:0] divisor,
    input  out_side_t         in_side,
    output logic              out_valid,
    output logic [H_W-1:0]    out_quot,
    output out_side_t         out_side
);

    logic              valid_reg [DIV_STAGES];
    logic              sat_reg   [DIV_STAGES];
    logic [CORR_W-1:0] rem_reg   [DIV_STAGES];
    logic [CORR_W-1:0] dvs_reg   [DIV_STAGES];
    logic [H_W-1:0]    lo_reg    [DIV_STAGES];
    logic [H_W-1:0]    q_reg     [DIV_STAGES];
    out_side_t         side_reg  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic              v_src;
            logic              sat_src;
            logic [CORR_W-1:0] rem_src;
            logic [CORR_W-1:0] dvs_src;
            logic [H_W-1:0]    lo_src;
            logic [H_W-1:0]    q_src;
            out_side_t         side_src;
            logic [CORR_W:0]   rem_sh;
            logic [CORR_W:0]   diff;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign v_src    = in_valid;
                assign sat_src  = {1'b0, num_hi} >= divisor;
                assign rem_src  = {1'b0, num_hi};
                assign dvs_src  = divisor;
                assign lo_src   = {num_lo, 8'b0};
                assign q_src    = '0;
                assign side_src = in_side;
            end
            else
            begin : g_next
                assign v_src    = valid_reg[k-1];
                assign sat_src  = sat_reg[k-1];
                assign rem_src  = rem_reg[k-1];
                assign dvs_src  = dvs_reg[k-1];
                assign lo_src   = lo_reg[k-1];
                assign q_src    = q_reg[k-1];
                assign side_src = side_reg[k-1];
            end

            assign rem_sh = {rem_src, lo_src[H_W-1]};
            assign diff   = rem_sh - {1'b0, dvs_src};
            assign ge     = rem_sh >= {1'b0, dvs_src};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                sat_reg[k]  <= sat_src;
                dvs_reg[k]  <= dvs_src;
                lo_reg[k]   <= {lo_src[H_W-2:0], 1'b0};
                q_reg[k]    <= {q_src[H_W-2:0], ge};
                rem_reg[k]  <= ge ? diff[CORR_W-1:0] : rem_sh[CORR_W-1:0];
                side_reg[k] <= side_src;
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = sat_reg[DIV_STAGES-1] ? '1 : q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

>>> rtl/raycast_wall_column_projection.sv
// Top level: raycaster wall column projection, config registers and output stage.
// Depends on rwcp_pkg, rwcp_dist, rwcp_cos, rwcp_sqrt, rwcp_div.
//
// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ---------------------------------------
// ray in    in         start & !busy            player_x/y, vert/horiz hits, headings
// result    out        done (one-cycle strobe)  hit, wall_x/y, distances, slice rows
// config    in         cfg_valid & cfg_ready    cfg_index, cfg_data
//
// One ray per clock; every result follows its start transaction through the distance,
// square root, fisheye multiply, divider and output stages: the 25-stage square root and
// the 24-stage divider give one bit per stage. busy is always low and cfg_ready always high.
// Reset clears the valid pipeline and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module raycast_wall_column_projection
    import rwcp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // ray transaction
    input  logic                      start,
    output logic                      busy,
    input  logic [COORD_W-1:0]        player_x,
    input  logic [COORD_W-1:0]        player_y,
    input  logic [COORD_W-1:0]        vert_hit_x,
    input  logic [COORD_W-1:0]        vert_hit_y,
    input  logic [COORD_W-1:0]        horiz_hit_x,
    input  logic [COORD_W-1:0]        horiz_hit_y,
    input  logic [HEAD_W-1:0]         ray_heading,
    input  logic [HEAD_W-1:0]         view_heading,
    // result transaction
    output logic                      done,
    output logic                      hit_is_horizontal,
    output logic [COORD_W-1:0]        wall_x,
    output logic [COORD_W-1:0]        wall_y,
    output logic [RAW_W-1:0]          raw_distance,
    output logic [CORR_W-1:0]         corrected_distance,
    output logic [H_W-1:0]            slice_height,
    output logic signed [CORR_W-1:0]  slice_top,
    output logic [CORR_W-1:0]         slice_bottom,
    // config transaction
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [23:0]               cfg_data
);

    // config registers
    logic [23:0]      proj_reg;
    logic [15:0]      tile_reg;
    logic [15:0]      screen_reg;
    logic [NUM_W-1:0] num_reg;      // tile_height * proj_plane_distance
    logic [22:0]      centre_reg;   // floor(screen_height / 2) in Q.8

    ray_in_t ray_in;

    logic            dist_valid;
    logic [SQ_W-1:0] dist_sq;
    side_t           dist_side;

    cos_t cos_val;
    cos_t cdly_reg [COS_DLY];

    logic             sq_valid;
    logic [RAW_W-1:0] sq_root;
    side_t            sq_side;

    // fisheye multiply stage
    logic               mv_reg;
    logic [41:0]        mul_reg;
    logic               pos_reg;
    logic [RAW_W-1:0]   raw_reg;
    side_t              mside_reg;
    logic [CORR_W-1:0]  corr_trunc;
    logic [CORR_W-1:0]  corr_next;
    out_side_t          div_in_side;

    logic           div_valid;
    logic [H_W-1:0] div_quot;
    out_side_t      div_side;

    // output stage
    logic                     done_reg;
    out_side_t                oside_reg;
    logic [H_W-1:0]           h_reg;
    logic signed [CORR_W-1:0] top_reg;
    logic [CORR_W-1:0]        bottom_reg;
    logic [H_W-2:0]           half;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_reg   <= 24'd70144;
            tile_reg   <= 16'd64;
            screen_reg <= 16'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                IDX_PROJ:   proj_reg   <= cfg_data;
                IDX_TILE:   tile_reg   <= cfg_data[15:0];
                IDX_SCREEN: screen_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // the user must change config only while idle (the block does not enforce it), so these trail harmlessly
    always_ff @(posedge clk)
    begin
        num_reg    <= tile_reg * proj_reg;
        centre_reg <= {screen_reg[15:1], 8'b0};
    end

    assign ray_in = '{px: player_x, py: player_y, vx: vert_hit_x, vy: vert_hit_y,
                      hx: horiz_hit_x, hy: horiz_hit_y};

    rwcp_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_ray    (ray_in),
        .out_valid (dist_valid),
        .out_sq    (dist_sq),
        .out_side  (dist_side)
    );

    rwcp_cos u_cos (
        .clk          (clk),
        .ray_heading  (ray_heading),
        .view_heading (view_heading),
        .out_cos      (cos_val)
    );

    // align cosine with the end of the square root
    always_ff @(posedge clk)
    begin
        cdly_reg[0] <= cos_val;
        for (int i = 1; i < COS_DLY; i++)
            cdly_reg[i] <= cdly_reg[i-1];
    end

    rwcp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_valid),
        .in_sq     (dist_sq),
        .in_side   (dist_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else
            mv_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        mul_reg   <= sq_root * cdly_reg[COS_DLY-1].mag;
        pos_reg   <= cdly_reg[COS_DLY-1].pos;
        raw_reg   <= sq_root;
        mside_reg <= sq_side;
    end

    // behind the viewer or below one LSB clamps to one LSB
    always_comb
    begin
        corr_trunc = mul_reg[CORR_W+15:16];
        corr_next  = (!pos_reg || corr_trunc == '0) ? CORR_W'(1) : corr_trunc;
        div_in_side.s    = mside_reg;
        div_in_side.raw  = raw_reg;
        div_in_side.corr = corr_next;
    end

    rwcp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mv_reg),
        .num_hi    (num_reg[NUM_W-1:16]),
        .num_lo    (num_reg[15:0]),
        .divisor   (corr_next),
        .in_side   (div_in_side),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    assign half = div_quot[H_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        oside_reg  <= div_side;
        h_reg      <= div_quot;
        top_reg    <= $signed({2'b00, centre_reg}) - $signed({2'b00, half});
        bottom_reg <= {2'b00, centre_reg} + {2'b00, half};
    end

    assign done               = done_reg;
    assign hit_is_horizontal  = oside_reg.s.horiz;
    assign wall_x             = oside_reg.s.wx;
    assign wall_y             = oside_reg.s.wy;
    assign raw_distance       = oside_reg.raw;
    assign corrected_distance = oside_reg.corr;
    assign slice_height       = h_reg;
    assign slice_top          = top_reg;
    assign slice_bottom       = bottom_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("result strobe missing after fixed latency");

    a_corr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (corrected_distance != '0))
        else $error("corrected distance below one LSB");

    a_slice_centered: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (({1'b0, slice_bottom} + {slice_top[CORR_W-1], slice_top})
                  == {2'b00, centre_reg, 1'b0}))
        else $error("slice not centered on screen");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == IDX_SCREEN)
        |=> (screen_reg == $past(cfg_data[15:0])))
        else $error("screen height write lost");
`endif

endmodule

>>> bench/raycast_wall_column_projection_test.sv
// Testbench for raycast_wall_column_projection: directed table, then random rays.
// Depends on rwcp_pkg and the block; results are checked against an in-bench predictor.
`timescale 1ns / 100ps

module raycast_wall_column_projection_test;
    import rwcp_pkg::*;

    // Ray transaction payload as driven on the input ports.
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] hy;
        logic [HEAD_W-1:0]  ray;
        logic [HEAD_W-1:0]  view;
    } ray_t;

    // One projected wall slice, as seen on the result ports.
    typedef struct packed {
        logic               horiz;
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
        logic [RAW_W-1:0]   raw;
        logic [CORR_W-1:0]  corr;
        logic [H_W-1:0]     height;
        logic [CORR_W-1:0]  top;
        logic [CORR_W-1:0]  bottom;
    } slice_t;

    // Directed row: ray, plus an optional typed-in slice.
    typedef struct {
        ray_t   r;
        bit     known;
        slice_t s;
    } row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [COORD_W-1:0]       player_x, player_y, vert_hit_x, vert_hit_y;
    logic [COORD_W-1:0]       horiz_hit_x, horiz_hit_y;
    logic [HEAD_W-1:0]        ray_heading, view_heading;
    logic                     done;
    logic                     hit_is_horizontal;
    logic [COORD_W-1:0]       wall_x, wall_y;
    logic [RAW_W-1:0]         raw_distance;
    logic [CORR_W-1:0]        corrected_distance;
    logic [H_W-1:0]           slice_height;
    logic signed [CORR_W-1:0] slice_top;
    logic [CORR_W-1:0]        slice_bottom;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [23:0]              cfg_data;

    raycast_wall_column_projection dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .player_x(player_x), .player_y(player_y),
        .vert_hit_x(vert_hit_x), .vert_hit_y(vert_hit_y),
        .horiz_hit_x(horiz_hit_x), .horiz_hit_y(horiz_hit_y),
        .ray_heading(ray_heading), .view_heading(view_heading),
        .done(done), .hit_is_horizontal(hit_is_horizontal),
        .wall_x(wall_x), .wall_y(wall_y),
        .raw_distance(raw_distance), .corrected_distance(corrected_distance),
        .slice_height(slice_height), .slice_top(slice_top), .slice_bottom(slice_bottom),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Bench copy of the configuration registers.
    logic [23:0] plane_dist;
    logic [15:0] tile_h;
    logic [15:0] screen_h;

    slice_t pending_slices[$];
    int     errors;
    int     sender_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: 1315 rays plus gaps and a few drains stay far below this.
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned dist_sq(logic [23:0] ax, logic [23:0] ay,
                                                logic [23:0] bx, logic [23:0] by);
        longint unsigned dx;
        longint unsigned dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return dx * dx + dy * dy;
    endfunction

    // Polynomial cosine of a binary angle, signed Q1.16.
    function automatic longint heading_cos(logic [HEAD_W-1:0] d);
        logic [31:0] a;
        logic [1:0]  quad;
        logic [29:0] rem;
        longint      t, u2, p, c;
        a    = {d, 16'd0};
        quad = a[31:30];
        rem  = a[29:0];
        t    = quad[0] ? longint'((32'h4000_0000 - rem) >> 14) : longint'(rem >> 14);
        u2   = (t * t) >>> 16;
        p    = 60;
        p    = 1367 - ((p * u2) >>> 16);
        p    = 16624 - ((p * u2) >>> 16);
        p    = 80852 - ((p * u2) >>> 16);
        c    = 65536 - ((p * u2) >>> 16);
        if (c < 0)
            c = 0;
        if (c > 65536)
            c = 65536;
        return (quad == 2'd1 || quad == 2'd2) ? -c : c;
    endfunction

    function automatic slice_t project_ray(ray_t r);
        slice_t          s;
        longint unsigned vd2, hd2, raw, corr, num, h;
        longint          c, centre, top, bottom;
        vd2     = dist_sq(r.px, r.py, r.vx, r.vy);
        hd2     = dist_sq(r.px, r.py, r.hx, r.hy);
        s.horiz = hd2 <= vd2;
        s.wx    = s.horiz ? r.hx : r.vx;
        s.wy    = s.horiz ? r.hy : r.vy;
        raw     = int_sqrt(s.horiz ? hd2 : vd2);
        c       = heading_cos(r.ray - r.view);
        corr    = 1;
        if (c > 0)
        begin
            corr = (raw * longint'(c)) >> 16;
            if (corr < 1)
                corr = 1;
        end
        num = (longint'(tile_h) * longint'(plane_dist)) << 8;
        h   = num / corr;
        if (h > 64'hFF_FFFF)
            h = 64'hFF_FFFF;
        centre   = longint'(screen_h >> 1) << 8;
        top      = centre - longint'(h >> 1);
        bottom   = centre + longint'(h >> 1);
        s.raw    = raw[RAW_W-1:0];
        s.corr   = corr[CORR_W-1:0];
        s.height = h[H_W-1:0];
        s.top    = top[CORR_W-1:0];
        s.bottom = bottom[CORR_W-1:0];
        return s;
    endfunction

    // Result monitor: done is a one-cycle strobe, sampled on the edge that ends it.
    always @(posedge clk)
    begin
        slice_t want;
        if (rst_n && done)
        begin
            if (pending_slices.size() == 0)
            begin
                $error("unexpected slice result");
                errors++;
            end
            else
            begin
                want = pending_slices.pop_front();
                if (hit_is_horizontal !== want.horiz)
                begin
                    $error("hit_is_horizontal exp %0d got %0d", want.horiz, hit_is_horizontal);
                    errors++;
                end
                if (wall_x !== want.wx)
                begin
                    $error("wall_x exp %0h got %0h", want.wx, wall_x);
                    errors++;
                end
                if (wall_y !== want.wy)
                begin
                    $error("wall_y exp %0h got %0h", want.wy, wall_y);
                    errors++;
                end
                if (raw_distance !== want.raw)
                begin
                    $error("raw_distance exp %0h got %0h", want.raw, raw_distance);
                    errors++;
                end
                if (corrected_distance !== want.corr)
                begin
                    $error("corrected_distance exp %0h got %0h", want.corr,
                           corrected_distance);
                    errors++;
                end
                if (slice_height !== want.height)
                begin
                    $error("slice_height exp %0h got %0h", want.height, slice_height);
                    errors++;
                end
                if (slice_top !== want.top)
                begin
                    $error("slice_top exp %0h got %0h", want.top, slice_top);
                    errors++;
                end
                if (slice_bottom !== want.bottom)
                begin
                    $error("slice_bottom exp %0h got %0h", want.bottom, slice_bottom);
                    errors++;
                end
            end
        end
    end

    // Wait for the pipeline to empty, then a margin past the full latency.
    task automatic drain_pipeline();
        while (pending_slices.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            IDX_PROJ:   plane_dist = val;
            IDX_TILE:   tile_h     = val[15:0];
            IDX_SCREEN: screen_h   = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drive one ray transaction; start stays high across back-to-back rays.
    task automatic send_ray(ray_t r, bit known, slice_t typed);
        slice_t s;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        player_x     <= r.px;
        player_y     <= r.py;
        vert_hit_x   <= r.vx;
        vert_hit_y   <= r.vy;
        horiz_hit_x  <= r.hx;
        horiz_hit_y  <= r.hy;
        ray_heading  <= r.ray;
        view_heading <= r.view;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        s = project_ray(r);
        if (known && s !== typed)
        begin
            $error("directed row disagrees with predictor: exp %h pred %h", typed, s);
            errors++;
        end
        pending_slices.push_back(known ? typed : s);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly walls within a few tiles of the player; some full-range noise.
    function automatic ray_t random_ray();
        ray_t r;
        int   k;
        k = $urandom_range(9);
        r.px = COORD_W'($urandom);
        r.py = COORD_W'($urandom);
        if (k < 7)
        begin
            r.px = COORD_W'($urandom_range(24'h40_0000, 24'hBF_FFFF));
            r.py = COORD_W'($urandom_range(24'h40_0000, 24'hBF_FFFF));
            r.vx = COORD_W'(r.px + $urandom_range(0, 24'h8_0000) - 24'h4_0000);
            r.vy = COORD_W'(r.py + $urandom_range(0, 24'h8_0000) - 24'h4_0000);
            r.hx = COORD_W'(r.px + $urandom_range(0, 24'h8_0000) - 24'h4_0000);
            r.hy = COORD_W'(r.py + $urandom_range(0, 24'h8_0000) - 24'h4_0000);
            r.view = HEAD_W'($urandom);
            // ray within the field of view
            r.ray  = HEAD_W'(r.view + $urandom_range(0, 16'h2AAA) - 16'h1555);
        end
        else
        begin
            r.vx = COORD_W'($urandom);
            r.vy = COORD_W'($urandom);
            r.hx = (k == 9) ? r.vx : COORD_W'($urandom);
            r.hy = (k == 9) ? r.vy : COORD_W'($urandom);
            r.ray  = HEAD_W'($urandom);
            r.view = HEAD_W'($urandom);
        end
        return r;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 < 40)
                sender_idle_pct = 10;
            else if (i % 150 < 100)
                sender_idle_pct = 75;
            else
                sender_idle_pct = 0;
            send_ray(random_ray(), 1'b0, '0);
            // sender holds off until the pipeline is empty
            if (i == count / 2)
            begin
                stop_sending();
                while (pending_slices.size() != 0)
                    @(posedge clk);
            end
        end
        stop_sending();
    endtask

    row_t directed[$];

    function automatic ray_t mk(logic [23:0] px, logic [23:0] py, logic [23:0] vx,
                                logic [23:0] vy, logic [23:0] hx, logic [23:0] hy,
                                logic [15:0] ray, logic [15:0] view);
        ray_t r;
        r = '{px, py, vx, vy, hx, hy, ray, view};
        return r;
    endfunction

    task automatic add_row(ray_t r, bit known = 1'b0, slice_t s = '0);
        row_t row;
        row.r = r;
        row.known = known;
        row.s = s;
        directed.push_back(row);
    endtask

    initial
    begin
        errors          = 0;
        sender_idle_pct = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        player_x        = '0;
        player_y        = '0;
        vert_hit_x      = '0;
        vert_hit_y      = '0;
        horiz_hit_x     = '0;
        horiz_hit_y     = '0;
        ray_heading     = '0;
        view_heading    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = IDX_PROJ;
        cfg_data        = '0;
        plane_dist      = 24'd70144;
        tile_h          = 16'd64;
        screen_h        = 16'd480;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Player on the wall at reset defaults: corrected distance clamps to one,
        // height saturates, top/bottom spread around row 240.
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                '{1'b1, 24'd0, 24'd0, 25'd0, 25'd1, 24'hFF_FFFF,
                  25'h180_F001, 25'h080_EFFF});
        // all-ones coordinates, tie goes horizontal
        add_row(mk('1, '1, '1, '1, '1, '1, '1, '1));
        // tie with distinct points, equal distance
        add_row(mk(24'h1000, 24'h1000, 24'h2000, 24'h1000, 24'h1000, 24'h2000, 0, 0));
        // vertical strictly nearer
        add_row(mk(24'h1000, 24'h1000, 24'h1100, 24'h1000, 24'h5000, 24'h1000, 0, 0));
        // extremes far apart
        add_row(mk(0, 0, '1, '1, '1, 0, 16'h4000, 0));
        add_row(mk('1, '1, 0, 0, 0, '1, 16'h0, 16'hFFFF));
        // around the quarter turns: cosine near zero, ray beside or behind the viewer
        add_row(mk(24'h1000, 0, 24'h9000, 0, 24'hA000, 0, 16'h4000, 0));
        add_row(mk(24'h1000, 0, 24'h9000, 0, 24'hA000, 0, 16'h8000, 0));
        add_row(mk(24'h1000, 0, 24'h9000, 0, 24'hA000, 0, 16'hC000, 0));
        add_row(mk(24'h1000, 0, 24'h9000, 0, 24'hA000, 0, 16'hC001, 0));
        add_row(mk(24'h1000, 0, 24'h9000, 0, 24'hA000, 0, 16'h3FFF, 0));
        // heading wraparound
        add_row(mk(24'h1000, 0, 24'h9000, 0, 24'hA000, 0, 16'h0010, 16'hFFF0));
        // tiny distance: product below one LSB
        add_row(mk(24'h1000, 24'h1000, 24'h1001, 24'h1000, 24'hFFFF, 24'h1000,
                   16'h3F00, 0));
        // long distance, small height
        add_row(mk(0, 0, 24'hFF_0000, 24'hFF_0000, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0));
        add_row(mk(24'hAA_AAAA, 24'h55_5555, 24'h55_5555, 24'hAA_AAAA,
                   24'h12_3456, 24'h65_4321, 16'hAAAA, 16'h5555));

        foreach (directed[i])
            send_ray(directed[i].r, directed[i].known, directed[i].s);
        stop_sending();
        drain_pipeline();

        random_phase(350);
        drain_pipeline();

        // Register extremes: maxima saturate heights, minima give tiny slices.
        write_reg(IDX_PROJ, 24'hFF_FFFF);
        write_reg(IDX_TILE, 24'h00_FFFF);
        write_reg(IDX_SCREEN, 24'h00_FFFF);
        random_phase(300);
        drain_pipeline();

        write_reg(IDX_PROJ, 24'd1);
        write_reg(IDX_TILE, 24'd1);
        write_reg(IDX_SCREEN, 24'd1);
        random_phase(300);
        drain_pipeline();

        write_reg(IDX_PROJ, 24'($urandom_range(1, 24'hFF_FFFF)));
        write_reg(IDX_TILE, 24'($urandom_range(1, 16'hFFFF)));
        write_reg(IDX_SCREEN, 24'($urandom_range(1, 16'hFFFF)));
        random_phase(350);
        drain_pipeline();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
